[rtl/caf_pkg.sv]
// Shared types and constants for the circular aperture flux block.
package caf_pkg;

    // Fixed field and register widths
    localparam int CENTER_W   = 24;
    localparam int RADIUS_W   = 15;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int COL_W      = 16;
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 32;
    localparam int ACC_W      = 56;

    // Subsampling grid
    localparam int SUBS      = 5;
    localparam int SUB_MID   = SUBS / 2;
    localparam int SUB_IDX_W = 3;
    localparam int WEIGHT_W  = 5;
    localparam int CNT_W     = 3;

    localparam logic [SUB_IDX_W-1:0] SUB_LAST    = SUB_IDX_W'(SUBS - 1);
    localparam logic [WEIGHT_W-1:0]  WEIGHT_FULL = WEIGHT_W'(SUBS * SUBS);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2
    } cfg_addr_t;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LIMITS,
        MUL_DIST,
        MUL_RADIUS,
        MUL_SUB
    } mul_op_t;

    typedef enum logic [1:0] {
        W_HOLD,
        W_ZERO,
        W_FULL,
        W_ADD
    } weight_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCALE,
        ST_ABS,
        ST_DIST,
        ST_SUM,
        ST_DECIDE,
        ST_SUBSQ,
        ST_SUBCNT,
        ST_WEIGH,
        ST_ACC
    } state_t;

    typedef struct packed {
        logic                 load;
        logic                 diff;
        logic                 scale;
        logic                 absval;
        logic                 d2;
        mul_op_t              mul_op;
        logic [SUB_IDX_W-1:0] sub_idx;
        weight_op_t           wop;
        logic                 prod;
        logic                 acc;
    } dp_cmd_t;

    typedef struct packed {
        logic far;
        logic outside;
        logic full;
        logic last;
        logic out_busy;
    } dp_status_t;

endpackage

[rtl/caf_ctrl.sv]
// Controller state machine sequencing one pixel through the datapath.
module caf_ctrl
    import caf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [SUB_IDX_W-1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_op  = MUL_IDLE;
        cmd.wop     = W_HOLD;
        cmd.sub_idx = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.absval = 1'b1;
                cmd.mul_op = MUL_LIMITS;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                // drop pixels that are out of reach on either axis alone
                if (status.far)
                begin
                    cmd.wop    = W_ZERO;
                    state_next = ST_WEIGH;
                end
                else
                begin
                    cmd.mul_op = MUL_DIST;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.d2     = 1'b1;
                cmd.mul_op = MUL_RADIUS;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.outside)
                begin
                    cmd.wop    = W_ZERO;
                    state_next = ST_WEIGH;
                end
                else if (status.full)
                begin
                    cmd.wop    = W_FULL;
                    state_next = ST_WEIGH;
                end
                else
                begin
                    cmd.wop    = W_ZERO;
                    k_next     = '0;
                    state_next = ST_SUBSQ;
                end
            end
            ST_SUBSQ:
            begin
                cmd.mul_op = MUL_SUB;
                if (k_reg == SUB_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_SUBCNT;
                end
                else
                begin
                    k_next = k_reg + SUB_IDX_W'(1);
                end
            end
            ST_SUBCNT:
            begin
                cmd.wop = W_ADD;
                if (k_reg == SUB_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_WEIGH;
                end
                else
                begin
                    k_next = k_reg + SUB_IDX_W'(1);
                end
            end
            ST_WEIGH:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // hold the last pixel until the output register is free
                if (!(status.last && status.out_busy))
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/caf_datapath.sv]
// Datapath: configuration, offsets, squaring multipliers, subsample count, accumulator.
module caf_datapath
    import caf_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [COL_W-1:0]      pixel_col,
    input  logic [ROW_W-1:0]      pixel_row,
    input  logic [PIX_W-1:0]      pixel_value,
    input  logic                  last_pixel,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [ACC_W-1:0]      flux_times_25,
    output logic                  flux_positive
);

    localparam int PW   = COORD_BITS + FRAC_BITS;
    localparam int DFW  = ((PW > CENTER_W) ? PW : CENTER_W) + 1;
    localparam int DXW  = DFW + 3;
    localparam int OW   = RADIUS_W + 3;
    localparam int SQW  = 2 * OW;
    localparam int D2W  = SQW + 1;
    localparam int SW   = OW + 2;
    localparam int PRW  = VALUE_BITS + WEIGHT_W + 1;
    localparam logic [OW-1:0] MARGIN = OW'(15 << (FRAC_BITS - 2));

    // configuration
    logic [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_CENTER_X: center_x_reg <= cfg_wdata[CENTER_W-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_wdata[CENTER_W-1:0];
                CFG_RADIUS:   radius_reg   <= cfg_wdata[RADIUS_W-1:0];
                default:      ;
            endcase
        end
    end

    // pixel capture
    logic [COORD_BITS-1:0]        col_reg, row_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic                         last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            last_reg <= last_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg   <= COORD_BITS'(pixel_col);
            row_reg   <= COORD_BITS'(pixel_row);
            value_reg <= VALUE_BITS'(pixel_value);
        end
    end

    // radius limits, in units of 1/(5 * 2^FRAC_BITS) pixel
    logic [OW-1:0] r5;
    assign r5 = {1'b0, radius_reg, 2'b00} + {3'b000, radius_reg};

    logic [OW-1:0] outer_reg, inner_reg;
    logic          has_inner_reg;
    logic signed [DFW-1:0] diffx_reg, diffy_reg;
    logic signed [DXW-1:0] dx_reg, dy_reg;
    logic [DXW-1:0]        adx_reg, ady_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            diffx_reg     <= DFW'({col_reg, {FRAC_BITS{1'b0}}}) - DFW'(center_x_reg);
            diffy_reg     <= DFW'({row_reg, {FRAC_BITS{1'b0}}}) - DFW'(center_y_reg);
            outer_reg     <= r5 + MARGIN;
            inner_reg     <= r5 - MARGIN;
            has_inner_reg <= (r5 > MARGIN);
        end
        if (cmd.scale)
        begin
            dx_reg <= (DXW'(diffx_reg) <<< 2) + DXW'(diffx_reg);
            dy_reg <= (DXW'(diffy_reg) <<< 2) + DXW'(diffy_reg);
        end
        if (cmd.absval)
        begin
            adx_reg <= dx_reg[DXW-1] ? DXW'(-dx_reg) : DXW'(dx_reg);
            ady_reg <= dy_reg[DXW-1] ? DXW'(-dy_reg) : DXW'(dy_reg);
        end
    end

    // subsample offsets: dx + (k - 2) * step, valid once the pixel is known near
    logic signed [SW-1:0] dx_s, dy_s, sub_off, ex_sum, ey_sum;
    logic [OW-1:0]        ex, ey;

    assign dx_s    = dx_reg[SW-1:0];
    assign dy_s    = dy_reg[SW-1:0];
    assign sub_off = (SW'(cmd.sub_idx) - SW'(SUB_MID)) <<< FRAC_BITS;
    assign ex_sum  = dx_s + sub_off;
    assign ey_sum  = dy_s + sub_off;
    assign ex      = ex_sum[SW-1] ? OW'(-ex_sum) : OW'(ex_sum);
    assign ey      = ey_sum[SW-1] ? OW'(-ey_sum) : OW'(ey_sum);

    // shared pair of squaring multipliers
    logic [OW-1:0]  mul_a, mul_b;
    logic [SQW-1:0] prod_a, prod_b;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_LIMITS:
            begin
                mul_a = outer_reg;
                mul_b = inner_reg;
            end
            MUL_DIST:
            begin
                mul_a = adx_reg[OW-1:0];
                mul_b = ady_reg[OW-1:0];
            end
            MUL_RADIUS:
            begin
                mul_a = r5;
                mul_b = r5;
            end
            MUL_SUB:
            begin
                mul_a = ex;
                mul_b = ey;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_a = mul_a * mul_a;
    assign prod_b = mul_b * mul_b;

    logic [SQW-1:0] outer_sq_reg, inner_sq_reg, sqdx_reg, sqdy_reg, r5sq_reg;
    logic [SQW-1:0] sqx_reg [SUBS];
    logic [SQW-1:0] sqy_reg [SUBS];
    logic [D2W-1:0] d2_reg;
    logic [SQW-1:0] sq_a;

    assign sq_a = prod_a;

    always_ff @(posedge clk)
    begin
        case (cmd.mul_op)
            MUL_LIMITS:
            begin
                outer_sq_reg <= sq_a;
                inner_sq_reg <= prod_b;
            end
            MUL_DIST:
            begin
                sqdx_reg <= sq_a;
                sqdy_reg <= prod_b;
            end
            MUL_RADIUS:
            begin
                r5sq_reg <= prod_b;
            end
            MUL_SUB:
            begin
                sqx_reg[cmd.sub_idx] <= sq_a;
                sqy_reg[cmd.sub_idx] <= prod_b;
            end
            default: ;
        endcase
        if (cmd.d2)
        begin
            d2_reg <= D2W'(sqdx_reg) + D2W'(sqdy_reg);
        end
    end

    // count subsamples of one row within the radius
    logic [SUBS-1:0]  hit;
    logic [CNT_W-1:0] row_cnt;

    always_comb
    begin
        row_cnt = '0;
        for (int i = 0; i < SUBS; i++)
        begin
            hit[i]  = (D2W'(sqx_reg[i]) + D2W'(sqy_reg[cmd.sub_idx])) <= D2W'(r5sq_reg);
            row_cnt = row_cnt + CNT_W'(hit[i]);
        end
    end

    logic [WEIGHT_W-1:0] weight_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.wop)
            W_ZERO:  weight_reg <= '0;
            W_FULL:  weight_reg <= WEIGHT_FULL;
            W_ADD:   weight_reg <= weight_reg + WEIGHT_W'(row_cnt);
            default: ;
        endcase
    end

    // weighting and accumulation
    logic signed [PRW-1:0] prod_reg;
    logic [ACC_W-1:0]      acc_reg, acc_sum;

    always_ff @(posedge clk)
    begin
        if (cmd.prod)
        begin
            prod_reg <= PRW'(value_reg) * $signed({1'b0, weight_reg});
        end
    end

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    logic out_valid_reg;
    logic [ACC_W-1:0] flux_reg;
    logic pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.acc)
            begin
                if (last_reg)
                begin
                    acc_reg       <= '0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc && last_reg)
        begin
            flux_reg <= acc_sum;
            pos_reg  <= !acc_sum[ACC_W-1] && (acc_sum != '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign flux_times_25 = flux_reg;
    assign flux_positive = pos_reg;

    assign status.far      = (adx_reg > DXW'(outer_reg)) || (ady_reg > DXW'(outer_reg));
    assign status.outside  = d2_reg > D2W'(outer_sq_reg);
    assign status.full     = has_inner_reg && (d2_reg < D2W'(inner_sq_reg));
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

[rtl/circular_aperture_flux.sv]
// The block takes a new pixel beat only once the previous one is accumulated. Pixels out of
// reach on an axis, pixels whose squared distance alone settles the weight and pixels
// whose 5x5 grid is counted take paths of rising length, set by the single pair of
// squaring multipliers and the row-by-row count; a last pixel holds while a sum waits.
// Reset (rst_n low, asynchronous) clears the controller, the centre and radius
// registers, the accumulator and the output valid flag.
module circular_aperture_flux
    import caf_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // pixel_col[15:0], pixel_row[31:16], pixel_value[63:32]
    input  logic                  s_tlast,   // last_pixel
    // flux results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // flux_times_25[55:0]
    output logic                  m_tuser    // flux_positive
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller takes one pixel beat at a time and walks it through
    // offset, distance classification, optional subsample count and the
    // weighted accumulate. The result sits in an output register, so the
    // next pixel beat is taken while the sum waits for the sink; only a
    // further last pixel holds until that register drains.
    caf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Unpack the pixel beat straight into the datapath capture registers.
    caf_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .pixel_col     (s_tdata[15:0]),
        .pixel_row     (s_tdata[31:16]),
        .pixel_value   (s_tdata[63:32]),
        .last_pixel    (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .flux_times_25 (m_tdata),
        .flux_positive (m_tuser)
    );

endmodule
